>>> rtl/metropolis_ising_spin_update_core_macros.svh
// Assertion macros shared by the spin update core RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef METROPOLIS_ISING_SPIN_UPDATE_CORE_MACROS_SVH
`define METROPOLIS_ISING_SPIN_UPDATE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MISU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MISU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/misu_pkg.sv
// Shared types, codes and constants for the Metropolis spin update core.
// No dependencies; imported by the core top level.
package misu_pkg;

  // Default lattice side
  localparam int unsigned LATTICE_SIDE_DEF = 16;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned COORD_W = 4;
  localparam int unsigned RND_W   = 16;
  localparam int unsigned SPIN_W  = 2;
  localparam int unsigned TIX_W   = 5;
  localparam int unsigned THR_W   = 17;
  localparam int unsigned SUM_W   = 5;

  // Acceptance table
  localparam int unsigned TABLE_SIZE = 25;
  localparam logic [THR_W-1:0] FULL_SCALE = 17'h1_0000;
  localparam logic [SUM_W-1:0] SUM_BIAS = 5'd12;

  // Neighbor walk
  localparam int unsigned NBR_COUNT = 12;
  localparam int unsigned NCNT_W    = 4;
  localparam logic [NCNT_W-1:0] NBR_LAST = 4'(NBR_COUNT - 1);

  // Opcodes
  localparam logic [OP_W-1:0] OP_ATTEMPT   = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_SPIN   = 2'd1;
  localparam logic [OP_W-1:0] OP_WR_THRESH = 2'd2;
  localparam logic [OP_W-1:0] OP_RD_SPIN   = 2'd3;

  // Spin codes (two's complement)
  localparam logic [SPIN_W-1:0] SPIN_ZERO = 2'b00;
  localparam logic [SPIN_W-1:0] SPIN_POS  = 2'b01;
  localparam logic [SPIN_W-1:0] SPIN_NEG  = 2'b11;

  // Per-axis neighbor offset
  typedef enum logic [1:0] {
    OFF_ZERO,
    OFF_PLUS,
    OFF_MINUS
  } off_e;

  typedef struct packed {
    off_e dx;
    off_e dy;
    off_e dz;
  } nbr_off_t;

  // Offsets of the 12 coupled neighbors, in summation order
  function automatic nbr_off_t nbr_offset(input logic [NCNT_W-1:0] idx);
    nbr_off_t o;
    o = '{dx: OFF_ZERO, dy: OFF_ZERO, dz: OFF_ZERO};
    case (idx)
      4'd0:  o.dx = OFF_MINUS;
      4'd1:  o.dx = OFF_PLUS;
      4'd2:  o.dy = OFF_MINUS;
      4'd3:  o.dy = OFF_PLUS;
      4'd4:  o.dz = OFF_MINUS;
      4'd5:  o.dz = OFF_PLUS;
      4'd6:  begin o.dx = OFF_MINUS; o.dy = OFF_PLUS;  end
      4'd7:  begin o.dx = OFF_PLUS;  o.dy = OFF_MINUS; end
      4'd8:  begin o.dx = OFF_MINUS; o.dz = OFF_PLUS;  end
      4'd9:  begin o.dx = OFF_PLUS;  o.dz = OFF_MINUS; end
      4'd10: begin o.dy = OFF_MINUS; o.dz = OFF_PLUS;  end
      4'd11: begin o.dy = OFF_PLUS;  o.dz = OFF_MINUS; end
      default: o = '{dx: OFF_ZERO, dy: OFF_ZERO, dz: OFF_ZERO};
    endcase
    return o;
  endfunction

endpackage

>>> rtl/metropolis_ising_spin_update_core.sv
// Metropolis spin update core: periodic cubic lattice plus acceptance table.
// Depends on misu_pkg, misu_ram and the assertion macro header.
//
// Usage: drive an item on the opcode/site/data ports and raise start; the item
// transfers at a rising edge with start high and busy low. Exactly one result
// follows, shown on spin_now_o, flipped_o, site_empty_o and aligned_sum_o for a
// single cycle while done_o is high; the receiver must take it then.
// An item passes the coordinate wrap state, which repeats while a coordinate is
// at least LATTICE_SIDE and subtracts LATTICE_SIDE from it (never when
// LATTICE_SIDE >= 16). A site spin write completes there; a spin read, table
// write or attempt on an empty site completes after the center read; an
// attempt on a magnetic site goes on to the neighbor reads and the decision.
// busy is low again in the done_o cycle, so a new item may transfer then. An
// attempt is bounded by the single lattice RAM port: one read for the site,
// twelve for the neighbors, then the write-back of a flipped spin.
// Reset: the acceptance table clears at once; the lattice is cleared by a pass
// over all LATTICE_SIDE**3 sites (4096 by default) with busy high throughout.
`include "metropolis_ising_spin_update_core_macros.svh"

module metropolis_ising_spin_update_core
  import misu_pkg::*;
#(
  parameter int unsigned LATTICE_SIDE = LATTICE_SIDE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic [COORD_W-1:0]       site_x_i,
  input  logic [COORD_W-1:0]       site_y_i,
  input  logic [COORD_W-1:0]       site_z_i,
  input  logic [RND_W-1:0]         random_fraction_i,
  input  logic signed [SPIN_W-1:0] spin_value_i,
  input  logic [TIX_W-1:0]         table_index_i,
  input  logic [THR_W-1:0]         threshold_value_i,
  output logic                     done_o,
  output logic signed [SPIN_W-1:0] spin_now_o,
  output logic                     flipped_o,
  output logic                     site_empty_o,
  output logic signed [SUM_W-1:0]  aligned_sum_o
);

  // Geometry
  localparam int unsigned DEPTH = LATTICE_SIDE * LATTICE_SIDE * LATTICE_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(LATTICE_SIDE);
  localparam int unsigned CRW   = (CW > COORD_W) ? CW : COORD_W;
  localparam logic [AW-1:0] ROW_STRIDE   = AW'(LATTICE_SIDE);
  localparam logic [AW-1:0] PLANE_STRIDE = AW'(LATTICE_SIDE * LATTICE_SIDE);
  localparam logic [AW-1:0] LAST_ADDR    = AW'(DEPTH - 1);
  localparam logic [CW-1:0] COORD_MAX    = CW'(LATTICE_SIDE - 1);
  localparam logic [CRW-1:0] SIDE_STEP   = CRW'(LATTICE_SIDE);

  // Sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WRAP   = 3'd2;
  localparam logic [2:0] ST_CTRW   = 3'd3;
  localparam logic [2:0] ST_NBR    = 3'd4;
  localparam logic [2:0] ST_LAST   = 3'd5;
  localparam logic [2:0] ST_DECIDE = 3'd6;

  // One step along an axis with periodic wrap
  function automatic logic [CW-1:0] coord_step(input logic [CW-1:0] c, input off_e o);
    logic [CW-1:0] r;
    case (o)
      OFF_PLUS:  r = (c == COORD_MAX) ? '0 : c + CW'(1);
      OFF_MINUS: r = (c == '0) ? COORD_MAX : c - CW'(1);
      default:   r = c;
    endcase
    return r;
  endfunction

  // Linear lattice address, x major
  function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
    return AW'(x) * PLANE_STRIDE + AW'(y) * ROW_STRIDE + AW'(z);
  endfunction

  logic [2:0]              state_q, state_d;
  logic [AW-1:0]           clr_q, clr_d;
  logic [NCNT_W-1:0]       cnt_q, cnt_d;
  logic [OP_W-1:0]         op_q;
  logic [CRW-1:0]          x_q, x_d, y_q, y_d, z_q, z_d;
  logic [RND_W-1:0]        rnd_q;
  logic [SPIN_W-1:0]       sv_q;
  logic [TIX_W-1:0]        tix_q;
  logic [THR_W-1:0]        thr_q;
  logic [SPIN_W-1:0]       spin_q, spin_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [THR_W-1:0]        thr_tab_q [TABLE_SIZE];

  logic                    accept;
  logic                    in_range;
  logic [CW-1:0]           cx, cy, cz;
  nbr_off_t                noff;
  logic [AW-1:0]           ctr_addr, nbr_addr;
  logic                    mem_we;
  logic [AW-1:0]           mem_addr;
  logic [SPIN_W-1:0]       mem_wdata, mem_rdata;
  logic signed [SUM_W-1:0] nbr_spin;
  logic signed [SUM_W-1:0] aligned;
  logic [TIX_W-1:0]        lut_idx;
  logic                    flip;
  logic [SPIN_W-1:0]       wr_spin;
  logic                    tab_we;

  logic                    res_load;
  logic [SPIN_W-1:0]       res_spin;
  logic                    res_flip;
  logic signed [SUM_W-1:0] res_sum;
  logic                    done_q;
  logic [SPIN_W-1:0]       spin_now_q;
  logic                    flipped_q;
  logic signed [SUM_W-1:0] asum_q;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Coordinates reduced modulo the side
  assign in_range = (int'(x_q) < LATTICE_SIDE) && (int'(y_q) < LATTICE_SIDE) &&
                    (int'(z_q) < LATTICE_SIDE);
  assign cx = x_q[CW-1:0];
  assign cy = y_q[CW-1:0];
  assign cz = z_q[CW-1:0];

  // Address generation: center site or neighbor selected by cnt_q
  assign noff     = nbr_offset(cnt_q);
  assign ctr_addr = site_addr(cx, cy, cz);
  assign nbr_addr = site_addr(coord_step(cx, noff.dx), coord_step(cy, noff.dy),
                              coord_step(cz, noff.dz));

  // Spin from a write item: any negative pattern stores as -1
  assign wr_spin = (sv_q == SPIN_POS) ? SPIN_POS : (sv_q[1] ? SPIN_NEG : SPIN_ZERO);

  // Neighbor spin, sign extended
  assign nbr_spin = SUM_W'($signed(mem_rdata));

  // Acceptance test
  assign aligned = (spin_q == SPIN_POS) ? sum_q : -sum_q;
  assign lut_idx = TIX_W'(aligned) + SUM_BIAS;
  assign flip    = ({1'b0, rnd_q} < thr_tab_q[lut_idx]);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    spin_d    = spin_q;
    sum_d     = sum_q;
    mem_we    = 1'b0;
    mem_addr  = ctr_addr;
    mem_wdata = SPIN_ZERO;
    tab_we    = 1'b0;
    res_load  = 1'b0;
    res_spin  = mem_rdata;
    res_flip  = 1'b0;
    res_sum   = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          x_d     = CRW'(site_x_i);
          y_d     = CRW'(site_y_i);
          z_d     = CRW'(site_z_i);
          cnt_d   = '0;
          state_d = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (!in_range) begin
          if (int'(x_q) >= LATTICE_SIDE) x_d = x_q - SIDE_STEP;
          if (int'(y_q) >= LATTICE_SIDE) y_d = y_q - SIDE_STEP;
          if (int'(z_q) >= LATTICE_SIDE) z_d = z_q - SIDE_STEP;
        end else if (op_q == OP_WR_SPIN) begin
          mem_we    = 1'b1;
          mem_wdata = wr_spin;
          res_load  = 1'b1;
          res_spin  = wr_spin;
          state_d   = ST_IDLE;
        end else begin
          // center read issued here, data arrives next cycle
          state_d = ST_CTRW;
        end
      end
      ST_CTRW: begin
        spin_d   = mem_rdata;
        sum_d    = '0;
        mem_addr = nbr_addr;
        cnt_d    = cnt_q + NCNT_W'(1);
        if (op_q == OP_WR_THRESH) begin
          tab_we   = 1'b1;
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end else if (op_q == OP_RD_SPIN || mem_rdata == SPIN_ZERO) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_NBR;
        end
      end
      ST_NBR: begin
        mem_addr = nbr_addr;
        sum_d    = sum_q + nbr_spin;
        cnt_d    = cnt_q + NCNT_W'(1);
        if (cnt_q == NBR_LAST) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        sum_d   = sum_q + nbr_spin;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        mem_we    = flip;
        mem_wdata = SPIN_W'(-$signed(spin_q));
        res_load  = 1'b1;
        res_spin  = flip ? SPIN_W'(-$signed(spin_q)) : spin_q;
        res_flip  = flip;
        res_sum   = aligned;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      done_q  <= res_load;
    end
  end

  // Item and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      rnd_q <= random_fraction_i;
      sv_q  <= spin_value_i;
      tix_q <= table_index_i;
      thr_q <= threshold_value_i;
    end
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    spin_q <= spin_d;
    sum_q  <= sum_d;
    if (res_load) begin
      spin_now_q <= res_spin;
      flipped_q  <= res_flip;
      asum_q     <= res_sum;
    end
  end

  // Acceptance table, saturated on write, out-of-range index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        thr_tab_q[i] <= '0;
      end
    end else if (tab_we && (int'(tix_q) < TABLE_SIZE)) begin
      thr_tab_q[tix_q] <= (thr_q > FULL_SCALE) ? FULL_SCALE : thr_q;
    end
  end

  // Lattice storage
  misu_ram #(
    .WIDTH (SPIN_W),
    .DEPTH (DEPTH)
  ) u_lattice (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign done_o        = done_q;
  assign spin_now_o    = spin_now_q;
  assign flipped_o     = flipped_q;
  assign site_empty_o  = (spin_now_q == SPIN_ZERO);
  assign aligned_sum_o = asum_q;

  // Checks
  `MISU_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o, "done strobe repeated")
  `MISU_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy, "not busy after transfer")
  `MISU_ASSERT_IMP(a_flip_magnetic, clk_i, rst_ni, (state_q == ST_DECIDE) && flip, spin_q != SPIN_ZERO, "flip of an empty site")
  `MISU_ASSERT_IMP(a_flip_spin, clk_i, rst_ni, done_o && flipped_o, !site_empty_o && (aligned_sum_o != 5'sd0 || spin_now_o != SPIN_ZERO), "flipped result without spin")

endmodule

>>> rtl/misu_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; holds the lattice of the spin update core.
module misu_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write-first is not needed; read returns old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
